>>> rtl/dssl_pkg.sv
`default_nettype none

package dssl_pkg;

	// Angle limits and reset position, whole degrees
	localparam int unsigned ANGLE_W     = 8;
	localparam int unsigned PULSE_W     = 12;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX_DEF = 8'd180;
	localparam logic [ANGLE_W-1:0] ANGLE_HOME    = 8'd90;

	// Pulse mapping: 500 + floor(angle * 100 / 9)
	// 100/9 is folded into one constant: 100 * round(65536 / 9) = 728200,
	// the quotient is the top bits of the product (exact for angles up to 255)
	localparam logic [PULSE_W-1:0] PULSE_BASE  = 12'd500;
	localparam logic [19:0]        PULSE_SCALE = 20'd728200;
	localparam int unsigned        PROD_W      = ANGLE_W + 20;

	typedef logic [ANGLE_W-1:0] angle_t;
	typedef logic [PULSE_W-1:0] pulse_t;

	typedef enum logic [1:0] {
		OP_SET     = 2'd0,
		OP_COMMAND = 2'd1,
		OP_TICK    = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	function automatic pulse_t angle_to_pulse(input angle_t angle);
		logic [PROD_W-1:0] prod;
		begin
			prod = PROD_W'(angle) * PROD_W'(PULSE_SCALE);
			return PULSE_BASE + prod[PROD_W-1 -: PULSE_W];
		end
	endfunction

	function automatic angle_t clamp_angle(input angle_t raw, input angle_t max_angle);
		return (raw > max_angle) ? max_angle : raw;
	endfunction

	function automatic angle_t distance(input angle_t x, input angle_t y);
		return (x > y) ? (x - y) : (y - x);
	endfunction

endpackage

`default_nettype wire

>>> rtl/dual_servo_slew_limiter_top.sv
// Two-channel servo slew-rate limiter.
//
// Input stream (s_axis): one beat per operation. tuser carries the
// operation (set position, command targets, ramp tick, or a no-op that only
// reports); tdata carries the two requested angles, saturated to ANGLE_MAX.
// Output stream (m_axis): exactly one beat per input beat, in order, giving
// both pulse-width compare values from the updated current angles and a
// moving flag that is set while either channel still has ramp steps left.
//
// A beat taken from s_axis sits in the input register; the state update and the
// pulse mapping (one constant multiply per channel) load the result register
// from it. Throughput is one beat per cycle; the input register advances
// whenever the result register is empty or its beat is being taken in the
// same cycle.
//
// Reset puts both channels at 90 degrees with targets at 90 and no pending
// steps, and empties both registers. When the receiver stalls, the result
// holds, one further beat waits in the input register and s_axis_tready falls.
`default_nettype none

module dual_servo_slew_limiter_top #(
	parameter logic [dssl_pkg::ANGLE_W-1:0] ANGLE_MAX = dssl_pkg::ANGLE_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [7:0] angle_a, [15:8] angle_b
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation

	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [23:0] m_axis_tdata,   // [11:0] pulse_a, [23:12] pulse_b
	output      logic [0:0]  m_axis_tuser    // [0] moving
);

	import dssl_pkg::*;

	// Input register
	logic   valid_s1;
	op_t    op_s1;
	angle_t angle_a_s1;
	angle_t angle_b_s1;

	// Channel state
	angle_t cur_a_q, cur_b_q;
	angle_t tgt_a_q, tgt_b_q;
	angle_t steps_a_q, steps_b_q;

	// Result register
	logic   out_valid_q;
	pulse_t pulse_a_q, pulse_b_q;
	logic   moving_q;

	logic   advance;
	angle_t a_sat, b_sat;
	angle_t cur_a_d, cur_b_d, tgt_a_d, tgt_b_d, steps_a_d, steps_b_d;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Capture the incoming beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1      <= op_t'(s_axis_tuser);
			angle_a_s1 <= s_axis_tdata[7:0];
			angle_b_s1 <= s_axis_tdata[15:8];
		end
	end

	// Work out the next channel state
	always_comb begin
		a_sat     = clamp_angle(angle_a_s1, ANGLE_MAX);
		b_sat     = clamp_angle(angle_b_s1, ANGLE_MAX);
		cur_a_d   = cur_a_q;
		cur_b_d   = cur_b_q;
		tgt_a_d   = tgt_a_q;
		tgt_b_d   = tgt_b_q;
		steps_a_d = steps_a_q;
		steps_b_d = steps_b_q;
		case (op_s1)
			OP_SET: begin
				cur_a_d   = a_sat;
				cur_b_d   = b_sat;
				steps_a_d = '0;
				steps_b_d = '0;
			end
			OP_COMMAND: begin
				tgt_a_d   = a_sat;
				tgt_b_d   = b_sat;
				steps_a_d = distance(a_sat, cur_a_q);
				steps_b_d = distance(b_sat, cur_b_q);
			end
			OP_TICK: begin
				if (steps_a_q != '0) begin
					if (tgt_a_q > cur_a_q) begin
						cur_a_d = cur_a_q + 1'b1;
					end else if (tgt_a_q < cur_a_q) begin
						cur_a_d = cur_a_q - 1'b1;
					end
					steps_a_d = steps_a_q - 1'b1;
				end
				if (steps_b_q != '0) begin
					if (tgt_b_q > cur_b_q) begin
						cur_b_d = cur_b_q + 1'b1;
					end else if (tgt_b_q < cur_b_q) begin
						cur_b_d = cur_b_q - 1'b1;
					end
					steps_b_d = steps_b_q - 1'b1;
				end
			end
			default: begin
				// no-op: report the present outputs only
			end
		endcase
	end

	// Commit state and load the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_a_q     <= ANGLE_HOME;
			cur_b_q     <= ANGLE_HOME;
			tgt_a_q     <= ANGLE_HOME;
			tgt_b_q     <= ANGLE_HOME;
			steps_a_q   <= '0;
			steps_b_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				cur_a_q   <= cur_a_d;
				cur_b_q   <= cur_b_d;
				tgt_a_q   <= tgt_a_d;
				tgt_b_q   <= tgt_b_d;
				steps_a_q <= steps_a_d;
				steps_b_q <= steps_b_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_a_q <= angle_to_pulse(cur_a_d);
			pulse_b_q <= angle_to_pulse(cur_b_d);
			moving_q  <= (steps_a_d != '0) || (steps_b_d != '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {pulse_b_q, pulse_a_q};
	assign m_axis_tuser  = moving_q;

	// Moving flag follows the committed step counts
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (m_axis_tuser[0] == ((steps_a_q != '0) || (steps_b_q != '0))))
		else $error("moving flag disagrees with step counts");

	// Current angles stay within range
	assert property (@(posedge clk) disable iff (!arst_n)
		(cur_a_q <= ANGLE_MAX) && (cur_b_q <= ANGLE_MAX))
		else $error("current angle above limit");

	// Nonzero pending steps match the remaining distance to target
	assert property (@(posedge clk) disable iff (!arst_n)
		((steps_a_q == '0) || (steps_a_q == distance(tgt_a_q, cur_a_q))) &&
		((steps_b_q == '0) || (steps_b_q == distance(tgt_b_q, cur_b_q))))
		else $error("step count does not match distance to target");

endmodule

`default_nettype wire
